>>> rtl/mcfb_pkg.sv
// Shared types, constants and MD5 tables for the MD5 cipher-feedback byte cipher.
// No dependencies; imported by every module of the block.
package mcfb_pkg;

	localparam int MAX_KEY_BYTES_DEF = 32;
	localparam int KLEN_W            = 6;
	localparam int WORD_W            = 64;
	localparam int CFG_ADDR_W        = 3;
	localparam int BLK_W             = 512;
	localparam int DIG_W             = 128;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_KEY0   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY1   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY2   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY3   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_KLEN   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_DECRYPT = 3'd5;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// one queued input beat
	typedef struct packed {
		logic       first;
		logic [7:0] data;
	} item_t;

	// request to the hash unit
	typedef struct packed {
		logic             start;
		logic [BLK_W-1:0] blk;
	} md5_req_t;

	// status back from the hash unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIG_W-1:0] digest;
	} md5_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_WKEY = 6'b000010,
		ST_PREP = 6'b000100,
		ST_HASH = 6'b001000,
		ST_WVEC = 6'b010000,
		ST_EMIT = 6'b100000
	} back_state_t;

	// per-round shift amount, indexed by {round[5:4], round[1:0]}
	function automatic logic [4:0] md5_s(input logic [3:0] idx);
		logic [4:0] s;
		unique case (idx)
			4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
			4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word index used in a round
	function automatic logic [3:0] md5_g(input logic [5:0] r);
		logic [3:0] g;
		unique case (r[5:4])
			2'd0:    g = r[3:0];
			2'd1:    g = 4'((r[3:0] * 4'd5) + 4'd1);
			2'd2:    g = 4'((r[3:0] * 4'd3) + 4'd5);
			default: g = 4'(r[3:0] * 4'd7);
		endcase
		return g;
	endfunction

	// round constants
	function automatic logic [31:0] md5_k(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/mcfb_front.sv
// Front end: accepts input beats and holds them in a two-entry queue.
// Depends on mcfb_pkg.
module mcfb_front
	import mcfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tuser,   // first_of_message
	input  logic       pop,
	output logic       q_valid,
	output item_t      q_item
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{first: s_tuser, data: s_tdata};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

endmodule

>>> rtl/mcfb_md5.sv
// Iterative MD5 compression of one 512-bit block, one round per cycle.
// Depends on mcfb_pkg.
module mcfb_md5
	import mcfb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  md5_req_t req,
	output md5_rsp_t rsp
);

	logic [BLK_W-1:0] blk_q;
	logic [31:0]      a_q, b_q, c_q, d_q, t_q;
	logic [5:0]       rnd_q;
	logic             run_q, fin_q, done_q;
	logic [DIG_W-1:0] dig_q;

	logic [31:0] f, sum, nb, nt;
	logic [63:0] rot2;
	logic [5:0]  rnd_n;

	// round function, with a + K + W precomputed one round ahead
	always_comb begin
		unique case (rnd_q[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (d_q & b_q) | (~d_q & c_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum   = t_q + f;
		rot2  = {sum, sum} << md5_s({rnd_q[5:4], rnd_q[1:0]});
		nb    = b_q + rot2[63:32];
		rnd_n = rnd_q + 6'd1;
		nt    = d_q + md5_k(rnd_n) + blk_q[{md5_g(rnd_n), 5'b0} +: 32];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			blk_q <= req.blk;
			a_q   <= IV_A;
			b_q   <= IV_B;
			c_q   <= IV_C;
			d_q   <= IV_D;
			t_q   <= IV_A + md5_k(6'd0) + req.blk[31:0];
			rnd_q <= 6'd0;
		end else if (run_q) begin
			a_q   <= d_q;
			b_q   <= nb;
			c_q   <= b_q;
			d_q   <= c_q;
			t_q   <= nt;
			rnd_q <= rnd_n;
		end
		if (fin_q) begin
			dig_q <= {IV_D + d_q, IV_C + c_q, IV_B + b_q, IV_A + a_q};
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fin_q  <= run_q && (rnd_q == 6'd63);
			done_q <= fin_q;
			if (req.start) run_q <= 1'b1;
			else if (run_q && (rnd_q == 6'd63)) run_q <= 1'b0;
		end
	end

	assign rsp.busy   = run_q || fin_q;
	assign rsp.done   = done_q;
	assign rsp.digest = dig_q;

endmodule

>>> rtl/mcfb_back.sv
// Back end: key registers, chain vector, rekey sequencing and the output register.
// Depends on mcfb_pkg; drives the mcfb_md5 unit.
module mcfb_back
	import mcfb_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [WORD_W-1:0]     cfg_wdata,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  pop,
	output md5_req_t              md5_req,
	input  md5_rsp_t              md5_rsp,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata
);

	logic [WORD_W-1:0] key0_q, key1_q, key2_q, key3_q;
	logic [KLEN_W-1:0] klen_q;
	logic              dec_q;

	back_state_t      state_q;
	item_t            cur_q;
	logic [DIG_W-1:0] vec_q;
	logic [DIG_W-1:0] kb_q;
	logic [3:0]       pos_q;
	logic [KLEN_W-1:0] kidx_q;
	logic [1:0]       cnt_q;
	logic             ovalid_q;
	logic [7:0]       odata_q;

	logic [4*WORD_W-1:0] key_all;
	logic [KLEN_W-1:0]   klen;
	logic [KLEN_W-1:0]   k1, k2, k3, k4;
	logic [BLK_W-1:0]    key_blk, vec_blk;
	logic                out_free;
	logic [7:0]          vbyte, res;

	function automatic logic [KLEN_W-1:0] knext(input logic [KLEN_W-1:0] k,
		input logic [KLEN_W-1:0] n);
		logic [KLEN_W-1:0] s;
		s = k + 1'b1;
		return (s == n) ? '0 : s;
	endfunction

	assign key_all = {key3_q, key2_q, key1_q, key0_q};

	// effective key length: zero reads as one, clamp at the maximum
	always_comb begin
		if (klen_q == '0) klen = KLEN_W'(1);
		else if (klen_q > KLEN_W'(MAX_KEY_BYTES)) klen = KLEN_W'(MAX_KEY_BYTES);
		else klen = klen_q;
	end

	// padded single block holding the key
	always_comb begin
		key_blk = '0;
		for (int j = 0; j < 33; j++) begin
			if ((j < 32) && (KLEN_W'(j) < klen)) begin
				key_blk[8*j +: 8] = key_all[8*(j%32) +: 8];
			end
			if (KLEN_W'(j) == klen) key_blk[8*j +: 8] = PAD_BYTE;
		end
		key_blk[8*56 +: 8] = {klen[4:0], 3'b000};
		key_blk[8*57 +: 8] = {7'b0, klen[5]};
	end

	// padded block holding vector xor cyclic key (16 bytes = 128 bits)
	always_comb begin
		vec_blk            = '0;
		vec_blk[DIG_W-1:0] = vec_q ^ kb_q;
		vec_blk[8*16 +: 8] = PAD_BYTE;
		vec_blk[8*56 +: 8] = 8'h80;
	end

	// four cyclic key indexes a cycle
	assign k1 = knext(kidx_q, klen);
	assign k2 = knext(k1, klen);
	assign k3 = knext(k2, klen);
	assign k4 = knext(k3, klen);

	assign out_free = !ovalid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign vbyte    = vec_q[{pos_q, 3'b000} +: 8];
	assign res      = vbyte ^ cur_q.data;

	always_comb begin
		md5_req.start = 1'b0;
		md5_req.blk   = vec_blk;
		if (pop && q_item.first) begin
			md5_req.start = 1'b1;
			md5_req.blk   = key_blk;
		end else if (state_q == ST_HASH) begin
			md5_req.start = 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			klen_q <= KLEN_W'(1);
			dec_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KEY0:    key0_q <= cfg_wdata;
				REG_KEY1:    key1_q <= cfg_wdata;
				REG_KEY2:    key2_q <= cfg_wdata;
				REG_KEY3:    key3_q <= cfg_wdata;
				REG_KLEN:    klen_q <= cfg_wdata[KLEN_W-1:0];
				REG_DECRYPT: dec_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// item capture, cyclic key bytes gathered four at a time in ST_PREP, and output data
	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_item;
		if (state_q == ST_PREP) begin
			kb_q <= {key_all[{k3[4:0], 3'b000} +: 8], key_all[{k2[4:0], 3'b000} +: 8],
				key_all[{k1[4:0], 3'b000} +: 8], key_all[{kidx_q[4:0], 3'b000} +: 8],
				kb_q[DIG_W-1:32]};
		end
		if ((state_q == ST_EMIT) && out_free) odata_q <= res;
	end

	// output valid: set on emit, held until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= ((state_q == ST_EMIT) && out_free) || (ovalid_q && !m_tready);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vec_q    <= '0;
			pos_q    <= '0;
			kidx_q   <= '0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					kidx_q <= '0;
					cnt_q  <= '0;
					if (q_valid) begin
						if (q_item.first) state_q <= ST_WKEY;
						else if (pos_q == 4'd0) state_q <= ST_PREP;
						else state_q <= ST_EMIT;
					end
				end
				ST_WKEY: begin
					if (md5_rsp.done) begin
						vec_q   <= md5_rsp.digest;
						pos_q   <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					kidx_q <= k4;
					cnt_q  <= 2'(cnt_q + 2'd1);
					if (cnt_q == 2'd3) state_q <= ST_HASH;
				end
				ST_HASH: state_q <= ST_WVEC;
				ST_WVEC: begin
					if (md5_rsp.done) begin
						vec_q   <= md5_rsp.digest;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						vec_q[{pos_q, 3'b000} +: 8] <= dec_q ? cur_q.data : res;
						pos_q   <= 4'(pos_q + 4'd1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

endmodule

>>> rtl/md5_cfb_byte_cipher_top.sv
// Byte-wise MD5 cipher-feedback encryptor/decryptor, top level.
// Input beat to output valid: mid-block, dispatch then emit; at position 0, dispatch, key
// gather, start, MD5 pass and emit; at a message start the key hash comes before these.
// Throughput: one byte at a time; each 16-byte block needs one MD5 pass, at its first byte,
// set by one MD5 round per cycle. Reset (arst_n, async, active low): vector and position zero,
// key length 1, encrypt. Depends on mcfb_pkg, front, md5, back.
module md5_cfb_byte_cipher_top
	import mcfb_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // data_byte
	input  logic                  s_tuser,   // first_of_message
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // result_byte
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [WORD_W-1:0]     cfg_wdata
);

	logic     q_valid;
	item_t    q_item;
	logic     pop;
	md5_req_t md5_req;
	md5_rsp_t md5_rsp;

	mcfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	mcfb_md5 u_md5 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md5_req),
		.rsp    (md5_rsp)
	);

	mcfb_back #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.md5_req   (md5_req),
		.md5_rsp   (md5_rsp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// queue is never popped empty
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("pop from empty queue");

	// hash unit is never restarted mid-pass
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md5_req.start |-> !md5_rsp.busy)
		else $error("hash started while busy");

	// a started pass reports busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		md5_req.start |=> md5_rsp.busy)
		else $error("hash did not start");

	// back-pressure on input only when queue holds items
	a_full: assert property (@(posedge clk) disable iff (!arst_n) !s_tready |-> q_valid)
		else $error("input stalled with empty queue");

endmodule
